// ----- hdl/cld_pkg.sv -----
`timescale 1ns / 1ps
package cld_pkg;

  localparam int DEF_MAX_OUT_STATES = 16;
  localparam int DEF_MAX_IN_STATES  = 16;

  // counts up to 256 need 9 bits
  localparam int CNT_W = 9;

  localparam logic signed [31:0] LOG_ZERO = 32'sh8000_0000;
  localparam logic signed [31:0] LOG_MAX  = 32'sh7fff_ffff;

  localparam int CORR_SIZE  = 256;
  localparam int CORR_SHIFT = 12;
  localparam longint E_STEP_Q30 = 64'd1008687096;
  localparam longint LN2_Q30    = 64'd744261118;
  localparam longint ONE_Q30    = 64'd1073741824;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_EVAL  = 2'd1,
    OP_ACC   = 2'd2,
    OP_EM    = 2'd3
  } cld_op_e;

  localparam logic [1:0] REG_PRIOR    = 2'd0;
  localparam logic [1:0] REG_USED_IN  = 2'd1;
  localparam logic [1:0] REG_USED_OUT = 2'd2;

  typedef struct packed {
    logic               done;
    logic signed [31:0] ln;
  } cld_ln_rsp_t;

  typedef logic signed [31:0] cld_tab_t [CORR_SIZE];

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'(LOG_MAX)) r = LOG_MAX;
    else if (v < 34'(LOG_ZERO)) r = LOG_ZERO;
    else r = v[31:0];
    return r;
  endfunction

  // elaboration-time log2 in Q16, same bit-serial scheme as the runtime unit
  function automatic longint log2_q16_c(input logic [63:0] v, input int fb);
    int p;
    logic [63:0] x;
    longint frac;
    logic found;
    p = 0;
    found = 1'b0;
    frac = 0;
    for (int k = 63; k > 0; k--) begin
      if (!found && v[k]) begin
        p = k;
        found = 1'b1;
      end
    end
    x = (p > 30) ? (v >> (p - 30)) : (v << (30 - p));
    for (int i = 0; i < 16; i++) begin
      x = (x * x) >> 30;
      if (x >= 64'h8000_0000) begin
        x = x >> 1;
        frac = frac | (longint'(1) << (15 - i));
      end
    end
    return (longint'(p) - longint'(fb)) * 65536 + frac;
  endfunction

  function automatic logic signed [31:0] ln_q16_c(input logic [63:0] v, input int fb);
    longint l;
    logic signed [31:0] r;
    if (v == 64'd0) begin
      r = LOG_ZERO;
    end else begin
      l = log2_q16_c(v, fb) * LN2_Q30 / ONE_Q30;
      if (l > longint'(LOG_MAX)) r = LOG_MAX;
      else if (l < longint'(LOG_ZERO)) r = LOG_ZERO;
      else r = l[31:0];
    end
    return r;
  endfunction

  function automatic cld_tab_t build_corr();
    cld_tab_t t;
    logic [63:0] y;
    y = 64'd1 << 30;
    for (int i = 0; i < CORR_SIZE; i++) begin
      t[i] = ln_q16_c((64'd1 << 30) + y, 30);
      y = (y * E_STEP_Q30) >> 30;
    end
    return t;
  endfunction

  // entry n holds ln(n + 1) in Q16
  function automatic cld_tab_t build_ln_cnt();
    cld_tab_t t;
    for (int i = 0; i < CORR_SIZE; i++) begin
      t[i] = ln_q16_c(64'(i + 1), 0);
    end
    return t;
  endfunction

  localparam cld_tab_t CORR_TAB   = build_corr();
  localparam cld_tab_t LN_CNT_TAB = build_ln_cnt();

  function automatic logic signed [31:0] log_mul(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [31:0] r;
    if (a == LOG_ZERO || b == LOG_ZERO) r = LOG_ZERO;
    else r = sat32(34'(a) + 34'(b));
    return r;
  endfunction

  function automatic logic signed [31:0] log_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [31:0] m;
    logic signed [31:0] n;
    logic signed [32:0] dif;
    logic [20:0] idx;
    logic signed [31:0] c;
    logic signed [31:0] r;
    m = (a > b) ? a : b;
    n = (a > b) ? b : a;
    dif = 33'(m) - 33'(n);
    idx = dif[32:CORR_SHIFT];
    c = (idx < 21'(CORR_SIZE)) ? CORR_TAB[idx[7:0]] : 32'sd0;
    if (a == LOG_ZERO) r = b;
    else if (b == LOG_ZERO) r = a;
    else r = sat32(34'(m) + 34'(c));
    return r;
  endfunction

endpackage

// ----- hdl/cld_if.sv -----
`timescale 1ns / 1ps
interface cld_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic [3:0]         in_state;
  logic [3:0]         out_row;
  logic signed [31:0] log_derivative;
  logic signed [31:0] log_input;
  logic               has_input;
  logic signed [31:0] sample_log_prob;
  logic signed [31:0] prior_in_derivative;
  logic signed [31:0] new_weight;

  modport source (output valid, operation, in_state, out_row, log_derivative, log_input,
                  has_input, sample_log_prob, prior_in_derivative, new_weight,
                  input ready);
  modport sink (input valid, operation, in_state, out_row, log_derivative, log_input,
                has_input, sample_log_prob, prior_in_derivative, new_weight,
                output ready);
endinterface

interface cld_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] log_output;
  logic signed [31:0] in_derivative;
  logic [4:0]         rows_skipped;

  modport source (output valid, log_output, in_derivative, rows_skipped, input ready);
  modport sink (input valid, log_output, in_derivative, rows_skipped, output ready);
endinterface

// ----- hdl/cpt_log_domain_em_engine_core.sv -----
`timescale 1ns / 1ps
// Log-domain EM engine for one conditional-probability factor.
// Items enter on in_i (valid/ready) and each gives exactly one result item on
// out_o. Weights and betas live in two one-port-read RAMs addressed {row, col}.
// Configuration (prior, used columns, used rows) the user must write through
// cfg_we_i / cfg_idx_i / cfg_wdata_i while the engine is idle; not enforced.
// Write and evaluate go execute -> done, accumulate execute -> acc -> done.
// One item is in work at a time; the next is taken once the result sits in
// the output register. While a stalled receiver holds it, the next result
// waits in done. EM update: the ln(prior) unit runs first, then for each used
// row the responsibility sum over the used columns, then, unless that sum is
// log zero, a rewrite of the row's used columns; last a beta clearing sweep
// over all 2^(row bits + col bits) entries (256 at the default size).
// Reset: after rst_ni rises the same sweep fills every beta entry with log
// zero; in_i.ready stays low until it is done.
// Weights are undefined until written.
module cpt_log_domain_em_engine_core
  import cld_pkg::*;
#(
  parameter int MAX_OUT_STATES = DEF_MAX_OUT_STATES,
  parameter int MAX_IN_STATES  = DEF_MAX_IN_STATES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  cld_in_if.sink      in_i,
  cld_out_if.source   out_o
);

  localparam int RW    = (MAX_OUT_STATES > 1) ? $clog2(MAX_OUT_STATES) : 1;
  localparam int CW    = (MAX_IN_STATES > 1) ? $clog2(MAX_IN_STATES) : 1;
  localparam int AW    = RW + CW;
  localparam int DEPTH = 1 << AW;

  typedef enum logic [14:0] {
    S_INIT    = 15'h0001,
    S_IDLE    = 15'h0002,
    S_EXEC    = 15'h0004,
    S_ACC     = 15'h0008,
    S_LOGU    = 15'h0010,
    S_SUM_RD  = 15'h0020,
    S_SUM_MUL = 15'h0040,
    S_SUM_ADD = 15'h0080,
    S_Z       = 15'h0100,
    S_UPD_RD  = 15'h0200,
    S_UPD_MUL = 15'h0400,
    S_UPD_ADD = 15'h0800,
    S_UPD_WR  = 15'h1000,
    S_BCLR    = 15'h2000,
    S_DONE    = 15'h4000
  } state_e;

  // configuration
  logic [31:0] prior_q;
  logic [4:0]  used_in_q, used_out_q;

  state_e  state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic          out_valid_q, out_valid_d;

  // item registers
  cld_op_e            op_q, op_d;
  logic [AW-1:0]      addr_q, addr_d;
  logic               ok_q, ok_d;
  logic signed [31:0] d_q, d_d, login_q, login_d, s_q, s_d, pd_q, pd_d, nw_q, nw_d;

  // datapath registers
  logic [RW-1:0]      row_q, row_d;
  logic [CW-1:0]      col_q, col_d;
  logic signed [31:0] sum_q, sum_d, p_q, p_d, num_q, num_d, z_q, z_d;
  logic signed [31:0] lu_q, lu_d, lsp_q, lsp_d, q_q, q_d, beta_q, beta_d;
  logic signed [31:0] res_log_q, res_log_d, res_der_q, res_der_d;
  logic [CNT_W-1:0]   skip_q, skip_d;
  logic signed [31:0] out_log_q, out_log_d, out_der_q, out_der_d;
  logic [4:0]         out_skip_q, out_skip_d;

  // clamped table size
  logic [CNT_W-1:0] u_in, u_out, ncol, nrow, ncol_m1, nrow_m1, in_row9, in_col9;
  logic             col_last, row_last, in_acc;
  logic [AW-1:0]    in_addr, em_addr, rd_addr;

  // RAM ports
  logic          w_we, b_we;
  logic [AW-1:0] w_waddr, b_waddr;
  logic [31:0]   w_wdata, b_wdata, w_rd_raw, b_rd_raw;
  logic signed [31:0] w_rd, b_rd;

  logic        lu_start;
  cld_ln_rsp_t lu_rsp;

  assign u_in    = CNT_W'(used_in_q);
  assign u_out   = CNT_W'(used_out_q);
  assign ncol    = (u_in == '0) ? CNT_W'(1)
                 : ((u_in > CNT_W'(MAX_IN_STATES)) ? CNT_W'(MAX_IN_STATES) : u_in);
  assign nrow    = (u_out == '0) ? CNT_W'(1)
                 : ((u_out > CNT_W'(MAX_OUT_STATES)) ? CNT_W'(MAX_OUT_STATES) : u_out);
  assign ncol_m1 = ncol - CNT_W'(1);
  assign nrow_m1 = nrow - CNT_W'(1);
  assign col_last = (col_q == ncol_m1[CW-1:0]);
  assign row_last = (row_q == nrow_m1[RW-1:0]);

  assign in_row9 = CNT_W'(in_i.out_row);
  assign in_col9 = CNT_W'(in_i.in_state);
  assign in_addr = {in_row9[RW-1:0], in_col9[CW-1:0]};
  assign em_addr = {row_q, col_q};
  assign rd_addr = (state_q == S_IDLE) ? in_addr : em_addr;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && (state_q == S_IDLE);

  assign w_rd = w_rd_raw;
  assign b_rd = b_rd_raw;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q && !out_o.ready;
    op_d        = op_q;
    addr_d      = addr_q;
    ok_d        = ok_q;
    d_d         = d_q;
    login_d     = login_q;
    s_d         = s_q;
    pd_d        = pd_q;
    nw_d        = nw_q;
    row_d       = row_q;
    col_d       = col_q;
    sum_d       = sum_q;
    p_d         = p_q;
    num_d       = num_q;
    z_d         = z_q;
    lu_d        = lu_q;
    lsp_d       = lsp_q;
    q_d         = q_q;
    beta_d      = beta_q;
    res_log_d   = res_log_q;
    res_der_d   = res_der_q;
    skip_d      = skip_q;
    out_log_d   = out_log_q;
    out_der_d   = out_der_q;
    out_skip_d  = out_skip_q;
    w_we        = 1'b0;
    w_waddr     = addr_q;
    w_wdata     = nw_q;
    b_we        = 1'b0;
    b_waddr     = addr_q;
    b_wdata     = LOG_ZERO;
    lu_start    = 1'b0;

    case (state_q)
      S_INIT: begin
        b_we    = 1'b1;
        b_waddr = clr_q;
        clr_d   = clr_q + AW'(1);
        if (clr_q == {AW{1'b1}}) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          op_d      = cld_op_e'(in_i.operation);
          addr_d    = in_addr;
          ok_d      = (in_row9 < nrow) && (in_col9 < ncol);
          d_d       = in_i.log_derivative;
          login_d   = in_i.has_input ? in_i.log_input : 32'sd0;
          s_d       = in_i.sample_log_prob;
          pd_d      = in_i.prior_in_derivative;
          nw_d      = in_i.new_weight;
          res_log_d = 32'sd0;
          res_der_d = 32'sd0;
          skip_d    = '0;
          state_d   = S_EXEC;
        end
      end
      S_EXEC: begin
        case (op_q)
          OP_WRITE: begin
            w_we    = ok_q;
            state_d = S_DONE;
          end
          OP_EVAL: begin
            res_log_d = ok_q ? log_mul(w_rd, login_q) : LOG_ZERO;
            state_d   = S_DONE;
          end
          OP_ACC: begin
            p_d     = log_mul(d_q, w_rd);
            beta_d  = b_rd;
            q_d     = sat32(34'(d_q) + 34'(login_q) - 34'(s_q));
            state_d = S_ACC;
          end
          default: begin
            lu_start = 1'b1;
            state_d  = S_LOGU;
          end
        endcase
      end
      S_ACC: begin
        if (ok_q && d_q != LOG_ZERO) begin
          res_der_d = log_add(pd_q, p_q);
          if (login_q != LOG_ZERO && q_q != LOG_ZERO) begin
            b_we    = 1'b1;
            b_wdata = log_add(beta_q, q_q);
          end
        end else begin
          res_der_d = pd_q;
        end
        state_d = S_DONE;
      end
      S_LOGU: begin
        if (lu_rsp.done) begin
          lu_d  = lu_rsp.ln;
          lsp_d = (lu_rsp.ln == LOG_ZERO) ? LOG_ZERO
                : sat32(34'(lu_rsp.ln) - 34'(LN_CNT_TAB[ncol_m1[7:0]]));
          row_d   = '0;
          col_d   = '0;
          sum_d   = LOG_ZERO;
          state_d = S_SUM_RD;
        end
      end
      S_SUM_RD: begin
        state_d = S_SUM_MUL;
      end
      S_SUM_MUL: begin
        p_d     = log_mul(b_rd, w_rd);
        state_d = S_SUM_ADD;
      end
      S_SUM_ADD: begin
        sum_d = log_add(sum_q, p_q);
        if (col_last) begin
          col_d   = '0;
          state_d = S_Z;
        end else begin
          col_d   = col_q + CW'(1);
          state_d = S_SUM_RD;
        end
      end
      S_Z: begin
        if (sum_q == LOG_ZERO) begin
          // zero responsibility: row kept as is
          skip_d = skip_q + CNT_W'(1);
          sum_d  = LOG_ZERO;
          col_d  = '0;
          if (row_last) begin
            clr_d   = '0;
            state_d = S_BCLR;
          end else begin
            row_d   = row_q + RW'(1);
            state_d = S_SUM_RD;
          end
        end else begin
          z_d     = log_add(sum_q, lu_q);
          state_d = S_UPD_RD;
        end
      end
      S_UPD_RD: begin
        state_d = S_UPD_MUL;
      end
      S_UPD_MUL: begin
        p_d     = log_mul(b_rd, w_rd);
        state_d = S_UPD_ADD;
      end
      S_UPD_ADD: begin
        num_d   = log_add(p_q, lsp_q);
        state_d = S_UPD_WR;
      end
      S_UPD_WR: begin
        w_we    = 1'b1;
        w_waddr = em_addr;
        w_wdata = (num_q == LOG_ZERO) ? LOG_ZERO : sat32(34'(num_q) - 34'(z_q));
        if (col_last) begin
          sum_d = LOG_ZERO;
          col_d = '0;
          if (row_last) begin
            clr_d   = '0;
            state_d = S_BCLR;
          end else begin
            row_d   = row_q + RW'(1);
            state_d = S_SUM_RD;
          end
        end else begin
          col_d   = col_q + CW'(1);
          state_d = S_UPD_RD;
        end
      end
      S_BCLR: begin
        b_we    = 1'b1;
        b_waddr = clr_q;
        clr_d   = clr_q + AW'(1);
        if (clr_q == {AW{1'b1}}) state_d = S_DONE;
      end
      S_DONE: begin
        // output register free or being emptied this cycle
        if (!out_valid_q || out_o.ready) begin
          out_log_d   = res_log_q;
          out_der_d   = res_der_q;
          out_skip_d  = skip_q[4:0];
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      prior_q     <= 32'd0;
      used_in_q   <= 5'd16;
      used_out_q  <= 5'd16;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_PRIOR:    prior_q    <= cfg_wdata_i;
          REG_USED_IN:  used_in_q  <= cfg_wdata_i[4:0];
          REG_USED_OUT: used_out_q <= cfg_wdata_i[4:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    addr_q     <= addr_d;
    ok_q       <= ok_d;
    d_q        <= d_d;
    login_q    <= login_d;
    s_q        <= s_d;
    pd_q       <= pd_d;
    nw_q       <= nw_d;
    row_q      <= row_d;
    col_q      <= col_d;
    sum_q      <= sum_d;
    p_q        <= p_d;
    num_q      <= num_d;
    z_q        <= z_d;
    lu_q       <= lu_d;
    lsp_q      <= lsp_d;
    q_q        <= q_d;
    beta_q     <= beta_d;
    res_log_q  <= res_log_d;
    res_der_q  <= res_der_d;
    skip_q     <= skip_d;
    out_log_q  <= out_log_d;
    out_der_q  <= out_der_d;
    out_skip_q <= out_skip_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.log_output    = out_log_q;
  assign out_o.in_derivative = out_der_q;
  assign out_o.rows_skipped  = out_skip_q;

  cld_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (w_waddr),
    .wdata_i (w_wdata),
    .raddr_i (rd_addr),
    .rdata_o (w_rd_raw)
  );

  cld_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_beta_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (b_waddr),
    .wdata_i (b_wdata),
    .raddr_i (rd_addr),
    .rdata_o (b_rd_raw)
  );

  cld_log_unit u_log (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (lu_start),
    .value_i (prior_q),
    .rsp_o   (lu_rsp)
  );

`ifndef SYNTH
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> (state_q == S_EXEC))
    else $error("accepted item did not enter execute");

  a_log_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lu_rsp.done |-> (state_q == S_LOGU))
    else $error("log unit finished outside EM wait");

  a_beta_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !b_we)
    else $error("beta write while idle");
`endif

endmodule

// ----- hdl/cld_ram.sv -----
`timescale 1ns / 1ps
module cld_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- hdl/cld_log_unit.sv -----
`timescale 1ns / 1ps
module cld_log_unit
  import cld_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] value_i,
  output cld_ln_rsp_t rsp_o
);

  // ln of an unsigned Q16.16 value: normalize, 16 squarings, scale by ln2
  typedef enum logic [4:0] {
    L_IDLE  = 5'b00001,
    L_NORM  = 5'b00010,
    L_SQ    = 5'b00100,
    L_SCALE = 5'b01000,
    L_DONE  = 5'b10000
  } lstate_e;

  localparam logic signed [31:0] LN2_S    = 32'sd744261118;
  localparam logic signed [52:0] ROUND_NEG = 53'sd1073741823;

  lstate_e            st_q, st_d;
  logic [31:0]        n_q, n_d;
  logic [4:0]         p_q, p_d;
  logic [30:0]        x_q, x_d;
  logic [3:0]         it_q, it_d;
  logic [15:0]        frac_q, frac_d;
  logic signed [31:0] res_q, res_d;

  logic [61:0]        sq;
  logic [31:0]        t;
  logic signed [5:0]  ex;
  logic signed [21:0] l2;
  logic signed [52:0] prod;
  logic signed [52:0] adj;

  always_comb begin
    st_d   = st_q;
    n_d    = n_q;
    p_d    = p_q;
    x_d    = x_q;
    it_d   = it_q;
    frac_d = frac_q;
    res_d  = res_q;
    sq     = 62'(x_q) * 62'(x_q);
    t      = sq[61:30];
    ex     = $signed({1'b0, p_q}) - 6'sd16;
    l2     = {ex, frac_q};
    prod   = l2 * LN2_S;
    adj    = prod + (prod < 0 ? ROUND_NEG : 53'sd0);
    case (st_q)
      L_IDLE: begin
        if (start_i) begin
          n_d = value_i;
          p_d = 5'd31;
          if (value_i == 32'd0) begin
            res_d = LOG_ZERO;
            st_d  = L_DONE;
          end else begin
            st_d = L_NORM;
          end
        end
      end
      L_NORM: begin
        if (n_q[31]) begin
          x_d    = n_q[31:1];
          it_d   = 4'd0;
          frac_d = 16'd0;
          st_d   = L_SQ;
        end else begin
          n_d = {n_q[30:0], 1'b0};
          p_d = p_q - 5'd1;
        end
      end
      L_SQ: begin
        if (t[31]) begin
          x_d = t[31:1];
          frac_d[4'd15 - it_q] = 1'b1;
        end else begin
          x_d = t[30:0];
        end
        it_d = it_q + 4'd1;
        if (it_q == 4'd15) st_d = L_SCALE;
      end
      L_SCALE: begin
        res_d = 32'(adj >>> 30);
        st_d  = L_DONE;
      end
      L_DONE: begin
        st_d = L_IDLE;
      end
      default: begin
        st_d = L_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= L_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    p_q    <= p_d;
    x_q    <= x_d;
    it_q   <= it_d;
    frac_q <= frac_d;
    res_q  <= res_d;
  end

  assign rsp_o.done = (st_q == L_DONE);
  assign rsp_o.ln   = res_q;

endmodule
